### rtl/csv_gamepad_record_parser_unit_assert.svh
// Assertion macros used by the record parser RTL (cgp_parser).
// Depends on nothing; define NO_ASSERTIONS to compile them away.
`ifndef CSV_GAMEPAD_RECORD_PARSER_UNIT_ASSERT_SVH
`define CSV_GAMEPAD_RECORD_PARSER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CGP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CGP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CGP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define CGP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/cgp_pkg.sv
// Package for the gamepad record parser: limits, character codes,
// status codes and the transaction structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cgp_pkg;

    localparam int MAX_LINE     = 32;
    localparam int COMMA_WINDOW = 17;
    localparam int BUTTON_COUNT = 12;

    localparam int NUM_VALUES = 4;
    localparam int VAL_W      = 16;
    localparam int BTN_OUT_W  = 12;
    localparam int CC_W       = 3;
    localparam int POS_LIM    = (MAX_LINE + 2 > COMMA_WINDOW + 1) ? MAX_LINE + 2
                                                                  : COMMA_WINDOW + 1;
    localparam int POS_W      = $clog2(POS_LIM);
    localparam int BCNT_W     = $clog2(BUTTON_COUNT + 1);

    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LONG  = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_rx_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] left_x;
        logic signed [VAL_W-1:0] left_y;
        logic signed [VAL_W-1:0] right_x;
        logic signed [VAL_W-1:0] right_y;
        logic [BTN_OUT_W-1:0]    buttons;
        logic [1:0]              status;
    } t_result;

endpackage

`default_nettype wire

### rtl/cgp_in_reg.sv
// Input register for received characters.
// Depends on cgp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cgp_in_reg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [7:0]      i_data,
    output logic                 o_stall,
    input  wire logic            i_advance,
    output cgp_pkg::t_rx_item    o_item
);
    import cgp_pkg::*;

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_data;
    logic       accept;

    assign o_stall = r_valid && !i_advance;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data <= i_data;
        end
    end

    assign o_item.valid = r_valid;
    assign o_item.data  = r_data;

endmodule

`default_nettype wire

### rtl/cgp_parser.sv
// Per-character record state update and result formation.
// Depends on cgp_pkg and csv_gamepad_record_parser_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "csv_gamepad_record_parser_unit_assert.svh"

module cgp_parser (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire cgp_pkg::t_rx_item i_item,
    input  wire logic            i_out_free,
    output logic                 o_advance,
    output logic                 o_res_load,
    output cgp_pkg::t_result     o_res
);
    import cgp_pkg::*;

    localparam logic [1:0] PH_SKIP   = 2'd0;
    localparam logic [1:0] PH_SIGN   = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    localparam logic [VAL_W-1:0] MAG_SAT = 16'd32768;
    localparam logic [VAL_W-1:0] POS_MAX = 16'd32767;

    logic [POS_W-1:0]        r_pos,   n_pos;
    logic [CC_W-1:0]         r_comma, n_comma;
    logic [VAL_W-1:0]        r_vals [NUM_VALUES];
    logic                    r_neg,   n_neg;
    logic [1:0]              r_phase, n_phase;
    logic [VAL_W-1:0]        r_mag,   n_mag;
    logic [BUTTON_COUNT-1:0] r_btn,   n_btn;
    logic [BCNT_W-1:0]       r_bcnt,  n_bcnt;
    logic                    r_extra, n_extra;

    logic [7:0]       c;
    logic             is_nl;
    logic             is_digit;
    logic             is_space;
    logic             is_sep;
    logic             val_we;
    logic [3:0]       digit;
    logic [19:0]      mag_next;
    logic [VAL_W-1:0] mag_taken;
    logic [VAL_W-1:0] fin;

    assign c        = i_item.data;
    assign is_nl    = (c == CH_NL);
    assign is_digit = (c >= CH_0) && (c <= CH_9);
    assign is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    assign is_sep   = (c == CH_COMMA) && (r_pos < POS_W'(COMMA_WINDOW));
    assign digit    = 4'(c - CH_0);

    assign o_advance  = i_item.valid && (!is_nl || i_out_free);
    assign o_res_load = o_advance && is_nl;

    assign mag_next  = 20'({r_mag, 3'b000}) + 20'({r_mag, 1'b0}) + 20'(digit);
    assign mag_taken = (mag_next > 20'(MAG_SAT)) ? MAG_SAT : mag_next[VAL_W-1:0];
    assign fin       = r_neg ? (VAL_W'(0) - r_mag)
                             : ((r_mag > POS_MAX) ? POS_MAX : r_mag);

    assign val_we = o_advance && !is_nl && is_sep && (r_comma < CC_W'(NUM_VALUES));

    always_comb begin
        n_pos   = r_pos;
        n_comma = r_comma;
        n_neg   = r_neg;
        n_phase = r_phase;
        n_mag   = r_mag;
        n_btn   = r_btn;
        n_bcnt  = r_bcnt;
        n_extra = r_extra;
        if (is_nl) begin
            n_pos   = '0;
            n_comma = '0;
            n_neg   = 1'b0;
            n_phase = PH_SKIP;
            n_mag   = '0;
            n_btn   = '1;
            n_bcnt  = '0;
            n_extra = 1'b0;
        end else begin
            if (r_pos <= POS_W'(MAX_LINE)) begin
                n_pos = r_pos + POS_W'(1);
            end
            if (is_sep) begin
                if (r_comma < CC_W'(NUM_VALUES)) begin
                    n_comma = r_comma + CC_W'(1);
                    n_neg   = 1'b0;
                    n_phase = PH_SKIP;
                    n_mag   = '0;
                end else begin
                    n_extra = 1'b1;
                end
            end else if (r_comma < CC_W'(NUM_VALUES)) begin
                case (r_phase)
                    PH_SKIP: begin
                        if (is_space) begin
                            n_phase = PH_SKIP;
                        end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
                            n_neg   = (c == CH_MINUS);
                            n_phase = PH_SIGN;
                        end else if (is_digit) begin
                            n_mag   = mag_taken;
                            n_phase = PH_DIGITS;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    PH_SIGN, PH_DIGITS: begin
                        if (is_digit) begin
                            n_mag   = mag_taken;
                            n_phase = PH_DIGITS;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end else if (r_bcnt < BCNT_W'(BUTTON_COUNT)) begin
                for (int k = 0; k < BUTTON_COUNT; k++) begin
                    n_btn[k] = r_btn[k] && !((c == CH_0) && (r_bcnt == BCNT_W'(k)));
                end
                n_bcnt = r_bcnt + BCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_comma <= '0;
            r_neg   <= 1'b0;
            r_phase <= PH_SKIP;
            r_mag   <= '0;
            r_btn   <= '1;
            r_bcnt  <= '0;
            r_extra <= 1'b0;
        end else if (o_advance) begin
            r_pos   <= n_pos;
            r_comma <= n_comma;
            r_neg   <= n_neg;
            r_phase <= n_phase;
            r_mag   <= n_mag;
            r_btn   <= n_btn;
            r_bcnt  <= n_bcnt;
            r_extra <= n_extra;
        end
    end

    always_ff @(posedge i_clk) begin
        if (val_we) begin
            r_vals[r_comma[1:0]] <= fin;
        end
    end

    always_comb begin
        o_res = '0;
        if (r_pos > POS_W'(MAX_LINE)) begin
            o_res.status = ST_TOO_LONG;
        end else if ((r_comma != CC_W'(NUM_VALUES)) || r_extra) begin
            o_res.status = ST_MALFORMED;
        end else begin
            o_res.left_x  = $signed(r_vals[0]);
            o_res.left_y  = $signed(r_vals[1]);
            o_res.right_x = $signed(r_vals[2]);
            o_res.right_y = $signed(r_vals[3]);
            o_res.buttons = BTN_OUT_W'(r_btn);
            o_res.status  = ST_OK;
        end
    end

    `CGP_ASSERT_NEXT(a_nl_clears, i_clk, i_rst_n, o_res_load,
        (r_pos == '0) && (r_comma == '0) && (r_bcnt == '0) && !r_extra,
        "record state not cleared after newline")
    `CGP_ASSERT_IMPLY(a_btn_after_commas, i_clk, i_rst_n, r_bcnt != '0,
        r_comma == CC_W'(NUM_VALUES), "button taken before fourth comma")
    `CGP_ASSERT_NEXT(a_pos_counts, i_clk, i_rst_n,
        o_advance && !is_nl && (r_pos <= POS_W'(MAX_LINE)),
        r_pos == $past(r_pos) + POS_W'(1), "character position did not advance")

endmodule

`default_nettype wire

### rtl/cgp_out_reg.sv
// Result register holding one parsed record until the receiver takes it.
// Depends on cgp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cgp_out_reg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire cgp_pkg::t_result i_res,
    input  wire logic            i_stall,
    output logic                 o_free,
    output logic                 o_valid,
    output cgp_pkg::t_result     o_res
);
    import cgp_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

### rtl/csv_gamepad_record_parser_unit.sv
// Top level of the gamepad record parser.
// Depends on cgp_pkg, cgp_in_reg, cgp_parser and cgp_out_reg.
//
// Usage:
//   Input channel (i_rx_valid / o_rx_stall / i_rx_byte) carries one text
//   character per transaction. A newline closes the record.
//   Output channel (o_res_valid / i_res_stall / result fields) carries one
//   transaction per newline: four saturated stick values, twelve button
//   bits and a status (0 ok, 1 line too long, 2 malformed; zeros otherwise).
//   Throughput: one character per cycle while no newline waits for the result
//   register, set by the state update between the input register and the
//   state registers. An accepted newline sits in the input register, and its
//   result is loaded into the result register, from which the receiver takes it.
//   Stall: a waiting result does not block ordinary characters; only a
//   following newline waits in the input register until the result
//   register frees, and o_rx_stall stays high while it waits.
//   Reset: synchronous, active low; clears both registers' valid flags and
//   returns the record state to the start of a line.
`timescale 1ns / 1ps
`default_nettype none

module csv_gamepad_record_parser_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_rx_valid,
    output logic                            o_rx_stall,
    input  wire logic [7:0]                 i_rx_byte,
    output logic                            o_res_valid,
    input  wire logic                       i_res_stall,
    output logic signed [cgp_pkg::VAL_W-1:0] o_left_x,
    output logic signed [cgp_pkg::VAL_W-1:0] o_left_y,
    output logic signed [cgp_pkg::VAL_W-1:0] o_right_x,
    output logic signed [cgp_pkg::VAL_W-1:0] o_right_y,
    output logic [cgp_pkg::BTN_OUT_W-1:0]   o_buttons,
    output logic [1:0]                      o_status
);
    import cgp_pkg::*;

    t_rx_item item;
    t_result  res_next;
    t_result  res_out;
    logic     advance;
    logic     res_load;
    logic     out_free;

    cgp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_rx_valid),
        .i_data    (i_rx_byte),
        .o_stall   (o_rx_stall),
        .i_advance (advance),
        .o_item    (item)
    );

    cgp_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item),
        .i_out_free (out_free),
        .o_advance  (advance),
        .o_res_load (res_load),
        .o_res      (res_next)
    );

    cgp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_load),
        .i_res   (res_next),
        .i_stall (i_res_stall),
        .o_free  (out_free),
        .o_valid (o_res_valid),
        .o_res   (res_out)
    );

    assign o_left_x  = res_out.left_x;
    assign o_left_y  = res_out.left_y;
    assign o_right_x = res_out.right_x;
    assign o_right_y = res_out.right_y;
    assign o_buttons = res_out.buttons;
    assign o_status  = res_out.status;

endmodule

`default_nettype wire

### bench/tb_top.sv
// Self-checking testbench for csv_gamepad_record_parser_unit: random and
// directed text records, with predicted results checked against the output channel.
// Depends on cgp_pkg and the parser RTL.
`timescale 1ns / 1ps

module tb_top;
    import cgp_pkg::*;

    typedef enum logic [1:0] {SCAN_BLANK, SCAN_SIGN, SCAN_DIGITS, SCAN_DONE} t_scan_phase;

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_rx_valid  = 1'b0;
    logic [7:0]                  i_rx_byte   = 8'd0;
    logic                        i_res_stall = 1'b0;
    logic                        o_rx_stall;
    logic                        o_res_valid;
    logic signed [VAL_W-1:0]     o_left_x;
    logic signed [VAL_W-1:0]     o_left_y;
    logic signed [VAL_W-1:0]     o_right_x;
    logic signed [VAL_W-1:0]     o_right_y;
    logic [BTN_OUT_W-1:0]        o_buttons;
    logic [1:0]                  o_status;

    logic [7:0] line_bytes[$];
    t_result    expected_records[$];
    int         total_items = 0;
    int         bytes_sent  = 0;
    int         mismatches  = 0;
    logic       rx_taken    = 1'b0;
    logic       hold_on     = 1'b0;

    // record parser state
    int unsigned       line_len;
    int unsigned       sep_count;
    logic [VAL_W-1:0]  stick_vals [NUM_VALUES];
    bit                stick_neg;
    t_scan_phase       scan;
    int unsigned       stick_mag;
    logic [BTN_OUT_W-1:0] btn_bits;
    int unsigned       btn_seen;
    bit                extra_sep;

    csv_gamepad_record_parser_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_valid  (i_rx_valid),
        .o_rx_stall  (o_rx_stall),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .o_left_x    (o_left_x),
        .o_left_y    (o_left_y),
        .o_right_x   (o_right_x),
        .o_right_y   (o_right_y),
        .o_buttons   (o_buttons),
        .o_status    (o_status)
    );

    always #5 i_clk = ~i_clk;

    function void clear_stick();
        stick_neg = 1'b0;
        scan      = SCAN_BLANK;
        stick_mag = 0;
    endfunction

    function void clear_record();
        line_len  = 0;
        sep_count = 0;
        for (int k = 0; k < NUM_VALUES; k++) stick_vals[k] = '0;
        clear_stick();
        btn_bits  = BTN_OUT_W'((1 << BUTTON_COUNT) - 1);
        btn_seen  = 0;
        extra_sep = 1'b0;
    endfunction

    function logic [VAL_W-1:0] stick_value();
        if (stick_neg) return VAL_W'(0 - stick_mag);
        return VAL_W'((stick_mag > 32767) ? 32767 : stick_mag);
    endfunction

    function void add_digit(input int unsigned d);
        stick_mag = stick_mag * 10 + d;
        if (stick_mag > 32768) stick_mag = 32768;
        scan = SCAN_DIGITS;
    endfunction

    function void parse_record_byte(input logic [7:0] c, output bit done, output t_result res);
        int unsigned pos;
        bit          is_dig;
        done   = 1'b0;
        res    = '0;
        is_dig = (c >= CH_0 && c <= CH_9);
        pos    = line_len;
        if (c == CH_NL) begin
            done = 1'b1;
            if (line_len > MAX_LINE) begin
                res.status = ST_TOO_LONG;
            end else if (sep_count != NUM_VALUES || extra_sep) begin
                res.status = ST_MALFORMED;
            end else begin
                res.left_x  = stick_vals[0];
                res.left_y  = stick_vals[1];
                res.right_x = stick_vals[2];
                res.right_y = stick_vals[3];
                res.buttons = btn_bits;
                res.status  = ST_OK;
            end
            clear_record();
        end else begin
            if (line_len <= MAX_LINE) line_len++;
            if (c == CH_COMMA && pos < COMMA_WINDOW) begin
                if (sep_count < NUM_VALUES) begin
                    stick_vals[sep_count] = stick_value();
                    sep_count++;
                    clear_stick();
                end else begin
                    extra_sep = 1'b1;
                end
            end else if (sep_count < NUM_VALUES) begin
                case (scan)
                    SCAN_BLANK: begin
                        if (c == CH_PLUS || c == CH_MINUS) begin
                            stick_neg = (c == CH_MINUS);
                            scan      = SCAN_SIGN;
                        end else if (is_dig) begin
                            add_digit(c - CH_0);
                        end else if (c != CH_SPACE && !(c >= CH_TAB && c <= CH_CR)) begin
                            scan = SCAN_DONE;
                        end
                    end
                    SCAN_SIGN, SCAN_DIGITS: begin
                        if (is_dig) add_digit(c - CH_0);
                        else scan = SCAN_DONE;
                    end
                    default: begin
                    end
                endcase
            end else if (btn_seen < BUTTON_COUNT) begin
                if (c == CH_0) btn_bits[btn_seen] = 1'b0;
                btn_seen++;
            end
        end
    endfunction

    function void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function int load_phase();
        if (total_items == 0) return 0;
        if (bytes_sent * 3 < total_items) return 0;
        if (bytes_sent * 3 < total_items * 2) return 1;
        return 2;
    endfunction

    task automatic push_text(input string s);
        for (int k = 0; k < s.len(); k++) line_bytes.push_back(s[k]);
    endtask

    task automatic push_field();
        int         r;
        int         n;
        logic [7:0] ch;
        if ($urandom_range(3) == 0) begin
            ch = 8'($urandom_range(CH_CR, CH_TAB));
            if (ch == CH_NL) ch = CH_SPACE;
            line_bytes.push_back(ch);
        end
        r = $urandom_range(3);
        if (r == 0) line_bytes.push_back(CH_PLUS);
        else if (r == 1) line_bytes.push_back(CH_MINUS);
        r = $urandom_range(15);
        n = (r == 0) ? 0 : (r == 1) ? $urandom_range(5, 7) : $urandom_range(1, 2);
        for (int k = 0; k < n; k++) line_bytes.push_back(8'(CH_0 + $urandom_range(9)));
        if ($urandom_range(7) == 0) begin
            ch = 8'($urandom_range(126, 33));
            if (ch == CH_COMMA) ch = CH_PLUS;
            line_bytes.push_back(ch);
        end
    endtask

    task automatic push_buttons(input int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 45) line_bytes.push_back(CH_0);
            else if (r < 80) line_bytes.push_back(8'(CH_0 + 1));
            else line_bytes.push_back(8'($urandom_range(126, 32)));
        end
    endtask

    task automatic pad_to(input int start, input int goal);
        while (line_bytes.size() - start < goal)
            line_bytes.push_back(8'(CH_0 + $urandom_range(1)));
    endtask

    task automatic add_record();
        int kind;
        int start;
        int n;
        kind  = $urandom_range(99);
        start = line_bytes.size();
        if (kind < 88) begin
            n = NUM_VALUES;
            if (kind >= 70 && kind < 80) begin
                n = $urandom_range(0, 5);
                if (n == NUM_VALUES) n = 6;
            end
            for (int k = 0; k < n; k++) begin
                push_field();
                line_bytes.push_back(CH_COMMA);
            end
            if (kind >= 70 && kind < 80) begin
                push_field();
                push_buttons($urandom_range(0, 4));
            end else if (kind >= 80) begin
                pad_to(start, COMMA_WINDOW);
                for (int k = $urandom_range(1, 5); k > 0; k--)
                    line_bytes.push_back($urandom_range(1) ? CH_COMMA : CH_0);
            end else begin
                push_buttons($urandom_range(0, 14));
                if (kind >= 55) pad_to(start, $urandom_range(30, 40));
            end
        end else begin
            n = ($urandom_range(9) == 0) ? $urandom_range(41, 70) : $urandom_range(0, 40);
            for (int k = 0; k < n; k++) line_bytes.push_back(8'($urandom_range(255)));
        end
        line_bytes.push_back(CH_NL);
    endtask

    // sender
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_rx_valid || rx_taken)) begin
            if (line_bytes.size() != 0 &&
                $urandom_range(99) >= ((load_phase() == 0) ? 31 : (load_phase() == 1) ? 68 : 0)) begin
                i_rx_valid <= 1'b1;
                i_rx_byte  <= line_bytes.pop_front();
                bytes_sent <= bytes_sent + 1;
            end else begin
                i_rx_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        int pct;
        pct = (load_phase() == 0) ? 68 : (load_phase() == 1) ? 31 : 0;
        i_res_stall <= hold_on || ($urandom_range(99) < pct);
    end

    // long receiver hold-off while the sender keeps going
    initial begin
        wait (total_items > 0);
        while (bytes_sent < total_items * 2 / 3 + 20) @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    // monitor and predictor
    always @(posedge i_clk) begin
        t_result want;
        t_result next_rec;
        bit      done;
        if (i_rst_n) begin
            if (o_res_valid && !i_res_stall) begin
                if (expected_records.size() == 0) begin
                    $display("%0t: unexpected transaction, expected none, actual status %0d",
                             $time, o_status);
                    mismatches++;
                end else begin
                    want = expected_records.pop_front();
                    check_field("left_x", want.left_x, o_left_x);
                    check_field("left_y", want.left_y, o_left_y);
                    check_field("right_x", want.right_x, o_right_x);
                    check_field("right_y", want.right_y, o_right_y);
                    check_field("buttons", want.buttons, o_buttons);
                    check_field("status", want.status, o_status);
                end
            end
            if (i_rx_valid && !o_rx_stall) begin
                parse_record_byte(i_rx_byte, done, next_rec);
                if (done) expected_records.push_back(next_rec);
            end
            rx_taken <= i_rx_valid && !o_rx_stall;
        end else begin
            rx_taken <= 1'b0;
        end
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        clear_record();
        push_text("\n");
        push_text("-99999,+40000,+,x,0\n");
        while (line_bytes.size() < 1420) add_record();
        total_items = line_bytes.size();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (line_bytes.size() != 0 || i_rx_valid) @(posedge i_clk);
        while (expected_records.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
